// File: rtl/core/mprm_pkg.sv
// Shared types, constants and command structs of the matrix power row-max unit.
package mprm_pkg;

  // Default sizes
  localparam int MAX_ORDER_DEF = 16;
  localparam int FRAC_BITS_DEF = 24;

  // Field widths
  localparam int DATA_W     = 32;
  localparam int OP_W       = 2;
  localparam int RC_W       = 4;
  localparam int ORDER_W    = 5;
  localparam int POWER_W    = 16;
  localparam int START_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Opcodes
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd2;

  // Saturation bounds of the accumulator, in product width
  localparam logic signed [2*DATA_W-1:0] ACC_MAX =
    {{(DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [2*DATA_W-1:0] ACC_MIN =
    {{(DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic [RC_W-1:0]          row;
    logic [RC_W-1:0]          col;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] row_max;
    logic                     saturated;
  } out_item_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_COMPUTE,
    RES_READ
  } res_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_STEP_CHK,
    ST_MAC,
    ST_CMP_RD,
    ST_DRAIN,
    ST_WRITE,
    ST_STEP_END,
    ST_SCAN,
    ST_SCAN_DRAIN,
    ST_READ_WAIT,
    ST_RESULT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      s_we;        // write source matrix
    logic      s_re;        // read source matrix
    logic      p_re;        // read current product buffer
    logic      p_we;        // write a product buffer
    logic      p_wr_other;  // write goes to the other buffer, data from accumulator
    logic      mac_issue;
    logic      mac_first;
    logic      scan_issue;
    logic      scan_first;
    logic      sat_clr;
    logic      diff_clr;
    logic      flip;        // swap current and other buffers
    logic      out_load;
    res_kind_t out_kind;
    logic      rd_in_range;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic diff;             // some entry changed during this step
  } dp_status_t;

endpackage

// File: rtl/core/mprm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mprm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/mprm_datapath.sv
// Datapath: matrix memories, multiply-accumulate, row maximum and result register.
module mprm_datapath
  import mprm_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int IDX_W  = $clog2(MAX_ORDER),
  localparam int ADDR_W = 2 * IDX_W
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  input  logic [ADDR_W-1:0]        s_waddr,
  input  logic [ADDR_W-1:0]        s_raddr,
  input  logic [ADDR_W-1:0]        p_waddr,
  input  logic [ADDR_W-1:0]        p_raddr,
  input  logic signed [DATA_W-1:0] load_value,
  output dp_status_t               status,
  output out_item_t                out_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic signed [DATA_W-1:0]   s_rdata;
  logic signed [DATA_W-1:0]   b0_rdata;
  logic signed [DATA_W-1:0]   b1_rdata;
  logic signed [DATA_W-1:0]   cur_rdata;
  logic signed [DATA_W-1:0]   p_wdata;
  logic                       cur_sel;
  logic                       mac_v1;
  logic                       first1;
  logic                       prod_v;
  logic                       first2;
  logic signed [2*DATA_W-1:0] prod;
  logic signed [2*DATA_W-1:0] shifted;
  logic signed [2*DATA_W-1:0] acc_ext;
  logic signed [2*DATA_W-1:0] sum;
  logic signed [DATA_W-1:0]   acc;
  logic                       sat_flag;
  logic                       diff;
  logic                       scan_v1;
  logic                       sfirst1;
  logic signed [DATA_W-1:0]   rmax;
  logic                       b0_we;
  logic                       b1_we;
  logic                       wr_sel;

  // Source matrix store
  mprm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_src (
    .clk   (clk),
    .we    (cmd.s_we),
    .waddr (s_waddr),
    .wdata (load_value),
    .re    (cmd.s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // Ping-pong product buffers
  assign wr_sel = cmd.p_wr_other ? ~cur_sel : cur_sel;
  assign b0_we  = cmd.p_we & ~wr_sel;
  assign b1_we  = cmd.p_we & wr_sel;
  assign p_wdata = cmd.p_wr_other ? acc : s_rdata;

  mprm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_buf0 (
    .clk   (clk),
    .we    (b0_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (cmd.p_re),
    .raddr (p_raddr),
    .rdata (b0_rdata)
  );

  mprm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_buf1 (
    .clk   (clk),
    .we    (b1_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (cmd.p_re),
    .raddr (p_raddr),
    .rdata (b1_rdata)
  );

  assign cur_rdata = cur_sel ? b1_rdata : b0_rdata;

  // Floor shift and saturating add
  assign shifted = prod >>> FRAC_BITS;
  assign acc_ext = first2 ? '0 : {{DATA_W{acc[DATA_W-1]}}, acc};
  assign sum     = acc_ext + shifted;

  // Control flags of the pipelines
  always_ff @(posedge clk) begin
    if (rst) begin
      mac_v1   <= 1'b0;
      prod_v   <= 1'b0;
      scan_v1  <= 1'b0;
      cur_sel  <= 1'b0;
      sat_flag <= 1'b0;
      diff     <= 1'b0;
    end else begin
      mac_v1  <= cmd.mac_issue;
      prod_v  <= mac_v1;
      scan_v1 <= cmd.scan_issue;
      if (cmd.flip) begin
        cur_sel <= ~cur_sel;
      end
      if (cmd.sat_clr) begin
        sat_flag <= 1'b0;
      end else if (prod_v && (sum > ACC_MAX || sum < ACC_MIN)) begin
        sat_flag <= 1'b1;
      end
      if (cmd.diff_clr) begin
        diff <= 1'b0;
      end else if (cmd.p_we && cmd.p_wr_other && acc != cur_rdata) begin
        diff <= 1'b1;
      end
    end
  end

  // Multiply, accumulate and row maximum
  always_ff @(posedge clk) begin
    first1 <= cmd.mac_first;
    sfirst1 <= cmd.scan_first;
    if (mac_v1) begin
      prod   <= s_rdata * cur_rdata;
      first2 <= first1;
    end
    if (prod_v) begin
      if (sum > ACC_MAX) begin
        acc <= ACC_MAX[DATA_W-1:0];
      end else if (sum < ACC_MIN) begin
        acc <= ACC_MIN[DATA_W-1:0];
      end else begin
        acc <= sum[DATA_W-1:0];
      end
    end
    if (scan_v1) begin
      if (sfirst1 || cur_rdata > rmax) begin
        rmax <= cur_rdata;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_kind)
        RES_READ: begin
          out_data.entry_value <= cmd.rd_in_range ? cur_rdata : '0;
          out_data.row_max     <= '0;
          out_data.saturated   <= sat_flag;
        end
        RES_COMPUTE: begin
          out_data.entry_value <= '0;
          out_data.row_max     <= rmax;
          out_data.saturated   <= sat_flag;
        end
        default: begin
          out_data <= '0;
        end
      endcase
    end
  end

  assign status.diff = diff;

endmodule

// File: rtl/core/mprm_ctrl.sv
// Controller: configuration registers, handshakes and the compute sequencer.
module mprm_ctrl
  import mprm_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF,
  localparam int IDX_W  = $clog2(MAX_ORDER),
  localparam int ADDR_W = 2 * IDX_W,
  localparam int CNT_W  = $clog2(MAX_ORDER + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  dp_status_t            status,
  output dp_cmd_t               cmd,
  output logic [ADDR_W-1:0]     s_waddr,
  output logic [ADDR_W-1:0]     s_raddr,
  output logic [ADDR_W-1:0]     p_waddr,
  output logic [ADDR_W-1:0]     p_raddr
);

  state_t             state, state_next;
  logic [ORDER_W-1:0] cfg_order;
  logic [POWER_W-1:0] cfg_power;
  logic [START_W-1:0] cfg_start;
  logic [IDX_W-1:0]   i, i_next;
  logic [IDX_W-1:0]   j, j_next;
  logic [IDX_W-1:0]   k, k_next;
  logic [POWER_W-1:0] step, step_next;
  logic [CNT_W-1:0]   n_act, n_act_next;
  logic [CNT_W-1:0]   res_order, res_order_next;
  logic [IDX_W-1:0]   r_row, r_row_next;
  res_kind_t          kind, kind_next;
  logic               rd_ok, rd_ok_next;
  logic               out_valid_next;
  logic [CNT_W-1:0]   n_eff;
  logic [IDX_W-1:0]   r_eff;
  logic [IDX_W-1:0]   n_last;
  logic [IDX_W-1:0]   in_row;
  logic [IDX_W-1:0]   in_col;
  logic               last_i;
  logic               last_j;
  logic               last_k;
  logic               load_ok;
  logic               read_ok;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_order <= ORDER_W'(1);
      cfg_power <= POWER_W'(1);
      cfg_start <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ORDER: cfg_order <= cfg_data[ORDER_W-1:0];
        CFG_POWER: cfg_power <= cfg_data[POWER_W-1:0];
        CFG_START: cfg_start <= cfg_data[START_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective order and start row
  always_comb begin
    if (cfg_order == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(cfg_order) > MAX_ORDER) begin
      n_eff = CNT_W'(MAX_ORDER);
    end else begin
      n_eff = CNT_W'(cfg_order);
    end
    if (32'(cfg_start) < 32'(n_eff)) begin
      r_eff = IDX_W'(cfg_start);
    end else begin
      r_eff = IDX_W'(n_eff - CNT_W'(1));
    end
  end

  assign n_last  = IDX_W'(n_act - CNT_W'(1));
  assign last_i  = (i == n_last);
  assign last_j  = (j == n_last);
  assign last_k  = (k == n_last);
  assign in_row  = IDX_W'(in_data.row);
  assign in_col  = IDX_W'(in_data.col);
  assign load_ok = (32'(in_data.row) < MAX_ORDER) && (32'(in_data.col) < MAX_ORDER);
  assign read_ok = (32'(in_data.row) < 32'(res_order)) && (32'(in_data.col) < 32'(res_order));

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      res_order <= CNT_W'(1);
      i         <= '0;
      j         <= '0;
      k         <= '0;
      step      <= '0;
      n_act     <= CNT_W'(1);
      r_row     <= '0;
      kind      <= RES_ZERO;
      rd_ok     <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      res_order <= res_order_next;
      i         <= i_next;
      j         <= j_next;
      k         <= k_next;
      step      <= step_next;
      n_act     <= n_act_next;
      r_row     <= r_row_next;
      kind      <= kind_next;
      rd_ok     <= rd_ok_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    res_order_next = res_order;
    i_next         = i;
    j_next         = j;
    k_next         = k;
    step_next      = step;
    n_act_next     = n_act;
    r_row_next     = r_row;
    kind_next      = kind;
    rd_ok_next     = rd_ok;
    cmd            = '0;
    cmd.out_kind   = kind;
    cmd.rd_in_range = rd_ok;
    s_waddr        = {in_row, in_col};
    s_raddr        = {i, j};
    p_waddr        = {i, j};
    p_raddr        = {i, j};

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.opcode)
            OP_LOAD: begin
              cmd.s_we   = load_ok;
              kind_next  = RES_ZERO;
              state_next = ST_RESULT;
            end
            OP_COMPUTE: begin
              cmd.sat_clr    = 1'b1;
              n_act_next     = n_eff;
              res_order_next = n_eff;
              r_row_next     = r_eff;
              i_next         = '0;
              j_next         = '0;
              state_next     = ST_COPY_RD;
            end
            OP_READ: begin
              cmd.p_re   = 1'b1;
              p_raddr    = {in_row, in_col};
              rd_ok_next = read_ok;
              kind_next  = RES_READ;
              state_next = ST_READ_WAIT;
            end
            default: begin
              kind_next  = RES_ZERO;
              state_next = ST_RESULT;
            end
          endcase
        end
      end

      ST_READ_WAIT: begin
        state_next = ST_RESULT;
      end

      // Copy the source into the current buffer
      ST_COPY_RD: begin
        cmd.s_re   = 1'b1;
        state_next = ST_COPY_WR;
      end

      ST_COPY_WR: begin
        cmd.p_we = 1'b1;
        if (last_j) begin
          j_next = '0;
          if (last_i) begin
            i_next     = '0;
            step_next  = POWER_W'(1);
            state_next = ST_STEP_CHK;
          end else begin
            i_next     = i + IDX_W'(1);
            state_next = ST_COPY_RD;
          end
        end else begin
          j_next     = j + IDX_W'(1);
          state_next = ST_COPY_RD;
        end
      end

      ST_STEP_CHK: begin
        i_next = '0;
        j_next = '0;
        k_next = '0;
        if (step < cfg_power) begin
          cmd.diff_clr = 1'b1;
          state_next   = ST_MAC;
        end else begin
          state_next = ST_SCAN;
        end
      end

      // One dot product term per cycle
      ST_MAC: begin
        cmd.s_re      = 1'b1;
        cmd.p_re      = 1'b1;
        cmd.mac_issue = 1'b1;
        cmd.mac_first = (k == '0);
        s_raddr       = {i, k};
        p_raddr       = {k, j};
        if (last_k) begin
          k_next     = '0;
          state_next = ST_CMP_RD;
        end else begin
          k_next = k + IDX_W'(1);
        end
      end

      // Fetch the old entry for the fixed-point check
      ST_CMP_RD: begin
        cmd.p_re   = 1'b1;
        state_next = ST_DRAIN;
      end

      ST_DRAIN: begin
        state_next = ST_WRITE;
      end

      ST_WRITE: begin
        cmd.p_we       = 1'b1;
        cmd.p_wr_other = 1'b1;
        state_next     = ST_MAC;
        if (last_j) begin
          j_next = '0;
          if (last_i) begin
            i_next     = '0;
            state_next = ST_STEP_END;
          end else begin
            i_next = i + IDX_W'(1);
          end
        end else begin
          j_next = j + IDX_W'(1);
        end
      end

      // Stop early once the product repeats
      ST_STEP_END: begin
        j_next = '0;
        if (status.diff) begin
          cmd.flip   = 1'b1;
          step_next  = step + POWER_W'(1);
          state_next = ST_STEP_CHK;
        end else begin
          state_next = ST_SCAN;
        end
      end

      ST_SCAN: begin
        cmd.p_re       = 1'b1;
        cmd.scan_issue = 1'b1;
        cmd.scan_first = (j == '0);
        p_raddr        = {r_row, j};
        if (last_j) begin
          j_next     = '0;
          state_next = ST_SCAN_DRAIN;
        end else begin
          j_next = j + IDX_W'(1);
        end
      end

      ST_SCAN_DRAIN: begin
        kind_next  = RES_COMPUTE;
        state_next = ST_RESULT;
      end

      ST_RESULT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/matrix_power_row_max_unit.sv
// Top level of the matrix power row-max unit: controller plus datapath.
//
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | in_data (in_item_t)
// out     | output    | out_valid / out_ready | out_data (out_item_t)
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Load and read results go to the result register once the item is accepted; a
// read passes through a wait state for the buffer read data. Compute copies the
// source into a product buffer, runs multiply steps (at most power-1, fewer when
// the product stops changing) through one shared multiply-accumulate and one read
// port per matrix buffer, then scans the start row for its maximum. Synchronous
// reset clears control state; matrix contents are not cleared. One item is in work
// at a time; a finished result waits in the output register while the next item is accepted.
module matrix_power_row_max_unit
  import mprm_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = 2 * $clog2(MAX_ORDER);

  dp_cmd_t           cmd;
  dp_status_t        status;
  logic [ADDR_W-1:0] s_waddr;
  logic [ADDR_W-1:0] s_raddr;
  logic [ADDR_W-1:0] p_waddr;
  logic [ADDR_W-1:0] p_raddr;

  mprm_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .cmd       (cmd),
    .s_waddr   (s_waddr),
    .s_raddr   (s_raddr),
    .p_waddr   (p_waddr),
    .p_raddr   (p_raddr)
  );

  mprm_datapath #(.MAX_ORDER(MAX_ORDER), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .s_waddr    (s_waddr),
    .s_raddr    (s_raddr),
    .p_waddr    (p_waddr),
    .p_raddr    (p_raddr),
    .load_value (in_data.value),
    .status     (status),
    .out_data   (out_data)
  );

endmodule

// File: rtl/core/mprm_checker.sv
// Port-level checks of the matrix power row-max unit, bound to the top level.
module mprm_checker
  import mprm_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A waiting input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed while waiting");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // No result right after reset
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // One item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // A result carries either a read entry or a row maximum, never both
  a_one_field: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.entry_value == '0 || out_data.row_max == '0))
    else $error("both entry and row maximum nonzero");

endmodule

bind matrix_power_row_max_unit mprm_checker u_mprm_checker (.*);
